[rtl/tkd_pkg.sv]
// Shared types, byte constants, key codes and lookup tables for the escape key decoder.
package tkd_pkg;

  // Raw byte values that steer the sequence decode
  localparam logic [7:0] BYTE_ESC    = 8'd27;
  localparam logic [7:0] BYTE_LBRACK = 8'h5B;  // '['
  localparam logic [7:0] BYTE_SS3_O  = 8'h4F;  // 'O'
  localparam logic [7:0] BYTE_TILDE  = 8'h7E;  // '~'
  localparam logic [7:0] BYTE_DIG_0  = 8'h30;  // '0'
  localparam logic [7:0] BYTE_DIG_8  = 8'h38;  // '8'
  localparam logic [7:0] BYTE_UP_A   = 8'h41;  // 'A'
  localparam logic [7:0] BYTE_UP_F   = 8'h46;  // 'F'
  localparam logic [7:0] BYTE_UP_H   = 8'h48;  // 'H'

  localparam int unsigned KEY_W = 9;

  // Key codes
  localparam logic [KEY_W-1:0] KC_EMPTY   = 9'd0;
  localparam logic [KEY_W-1:0] KC_ESC     = 9'd27;
  localparam logic [KEY_W-1:0] KC_UP      = 9'd300;
  localparam logic [KEY_W-1:0] KC_DOWN    = 9'd301;
  localparam logic [KEY_W-1:0] KC_RIGHT   = 9'd302;
  localparam logic [KEY_W-1:0] KC_LEFT    = 9'd303;
  localparam logic [KEY_W-1:0] KC_HOME    = 9'd304;
  localparam logic [KEY_W-1:0] KC_END     = 9'd305;
  localparam logic [KEY_W-1:0] KC_DEL     = 9'd306;
  localparam logic [KEY_W-1:0] KC_PAGE_UP = 9'd307;
  localparam logic [KEY_W-1:0] KC_PAGE_DN = 9'd308;

  // Largest digit that the tilde table covers
  localparam logic [3:0] TILDE_MAX = 4'd8;

  // One input request
  typedef struct packed {
    logic [7:0] byte_value;
    logic       no_byte;
  } tkd_item_t;

  // Input stage toward the decoder
  typedef struct packed {
    logic      valid;
    tkd_item_t item;
  } tkd_stage_t;

  // ESC [ letter table, indexed by letter - 'A'; KC_EMPTY marks an empty entry
  function automatic logic [KEY_W-1:0] letter_key(input logic [2:0] idx);
    logic [KEY_W-1:0] k;
    case (idx)
      3'd0:    k = KC_UP;
      3'd1:    k = KC_DOWN;
      3'd2:    k = KC_RIGHT;
      3'd3:    k = KC_LEFT;
      3'd5:    k = KC_END;
      3'd7:    k = KC_HOME;
      default: k = KC_EMPTY;
    endcase
    return k;
  endfunction

  // ESC [ digit ~ table; KC_EMPTY marks an empty entry
  function automatic logic [KEY_W-1:0] tilde_key(input logic [3:0] digit);
    logic [KEY_W-1:0] k;
    case (digit)
      4'd1:    k = KC_HOME;
      4'd3:    k = KC_DEL;
      4'd4:    k = KC_END;
      4'd5:    k = KC_PAGE_UP;
      4'd6:    k = KC_PAGE_DN;
      4'd7:    k = KC_HOME;
      4'd8:    k = KC_END;
      default: k = KC_EMPTY;
    endcase
    return k;
  endfunction

endpackage

[rtl/tkd_in_stage.sv]
// Input register stage: captures one request and holds it until the decoder takes it.
module tkd_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tkd_pkg::tkd_item_t in_item,
  input  logic               take,
  output tkd_pkg::tkd_stage_t stage
);
  import tkd_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  tkd_item_t item_r;

  // Free when empty or when the held request moves on this cycle
  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

[rtl/tkd_decode.sv]
// Sequence decoder: phase state, held digit and the registered key result.
module tkd_decode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tkd_pkg::tkd_stage_t         stage,
  output logic                        take,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tkd_pkg::KEY_W-1:0]   out_key_code
);
  import tkd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_ESC       = 3'd1,
    PH_CSI       = 3'd2,
    PH_CSI_DIGIT = 3'd3,
    PH_SS3       = 3'd4
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [3:0]       digit_r, digit_nxt;
  logic             out_valid_r;
  logic [KEY_W-1:0] key_r;
  logic             has_key;
  logic [KEY_W-1:0] key_nxt;
  logic [KEY_W-1:0] table_key;
  logic [7:0]       b;
  logic             none;

  assign b    = stage.item.byte_value;
  assign none = stage.item.no_byte;

  // Decoder moves when the result register is free or drains this cycle
  assign take = stage.valid && (!out_valid_r || out_ready);

  // Next phase and key for the held request
  always_comb begin
    phase_nxt = PH_IDLE;
    digit_nxt = digit_r;
    has_key   = 1'b1;
    key_nxt   = KC_ESC;
    table_key = KC_EMPTY;
    if (phase_r == PH_IDLE) begin
      if (none) begin
        has_key = 1'b0;
      end else if (b != BYTE_ESC) begin
        key_nxt = {1'b0, b};
      end else begin
        phase_nxt = PH_ESC;
        has_key   = 1'b0;
      end
    end else if (!none) begin
      // Unexpected bytes fall through to ESC and return to idle
      unique case (phase_r)
        PH_ESC: begin
          if (b == BYTE_LBRACK) begin
            phase_nxt = PH_CSI;
            has_key   = 1'b0;
          end else if (b == BYTE_SS3_O) begin
            phase_nxt = PH_SS3;
            has_key   = 1'b0;
          end
        end
        PH_CSI: begin
          if (b >= BYTE_DIG_0 && b <= BYTE_DIG_8) begin
            digit_nxt = b[3:0];
            phase_nxt = PH_CSI_DIGIT;
            has_key   = 1'b0;
          end else if (b >= BYTE_UP_A && b <= BYTE_UP_H) begin
            table_key = letter_key(b[2:0] - 3'd1);
            key_nxt   = (table_key == KC_EMPTY) ? KC_ESC : table_key;
          end
        end
        PH_CSI_DIGIT: begin
          if (b == BYTE_TILDE && digit_r <= TILDE_MAX) begin
            table_key = tilde_key(digit_r);
            key_nxt   = (table_key == KC_EMPTY) ? KC_ESC : table_key;
          end
        end
        PH_SS3: begin
          if (b == BYTE_UP_H) begin
            key_nxt = KC_HOME;
          end else if (b == BYTE_UP_F) begin
            key_nxt = KC_END;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      digit_r     <= 4'd0;
      out_valid_r <= 1'b0;
      key_r       <= KC_EMPTY;
    end else if (take) begin
      phase_r     <= phase_nxt;
      digit_r     <= digit_nxt;
      out_valid_r <= has_key;
      if (has_key) begin
        key_r <= key_nxt;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key_code = key_r;

  // No-byte while idle never produces a result
  a_idle_none_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (take && phase_r == PH_IDLE && none) |=> !out_valid_r)
    else $error("result from no-byte event while idle");

  // ESC while idle opens a sequence without a result
  a_esc_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (take && phase_r == PH_IDLE && !none && b == BYTE_ESC)
      |=> (phase_r == PH_ESC && !out_valid_r))
    else $error("ESC did not open a sequence");

  // Any result ends a sequence
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (take && has_key) |=> (phase_r == PH_IDLE))
    else $error("phase not idle after a result");

  // Key codes stay in the defined ranges
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (key_r < 9'd256 || (key_r >= KC_UP && key_r <= KC_PAGE_DN)))
    else $error("key code out of range");

  // Held digit only ever takes tilde table indexes
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    digit_r <= TILDE_MAX)
    else $error("held digit out of range");

endmodule

[rtl/terminal_escape_key_decoder.sv]
// Top level of the terminal escape key decoder.
// Usage:
//   The input channel (in_valid/in_ready) takes one request per cycle unless
//   stalled: a raw terminal byte in in_byte_value, or a no-byte event (end of
//   input or timeout) flagged by in_no_byte, in which case the byte is ignored.
//   The result channel (out_valid/out_ready) gives key codes on out_key_code:
//   0..255 for a plain byte or ESC, 300..308 for arrows, home, end, delete,
//   page up and page down. Bytes that open or continue an escape sequence,
//   and a no-byte event outside a sequence, give no result.
// Pipeline:
//   One request per cycle sustained while out_ready stays high. A request
//   moves from the input register through the phase decode into the
//   result register.
// Reset (rst_n low, synchronous) empties both registers and returns to the
//   idle phase with no sequence open.
// Stalls: while out_ready is low a finished key waits in the result register;
//   one more request is still taken into the input register, after which
//   in_ready drops until the result is taken.
module terminal_escape_key_decoder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_byte_value,
  input  logic                      in_no_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [tkd_pkg::KEY_W-1:0] out_key_code
);
  import tkd_pkg::*;

  tkd_item_t  in_item;
  tkd_stage_t stage;
  logic       take;

  assign in_item.byte_value = in_byte_value;
  assign in_item.no_byte    = in_no_byte;

  tkd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .stage    (stage)
  );

  tkd_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .stage        (stage),
    .take         (take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_key_code (out_key_code)
  );

endmodule

[dv/tb.sv]
// Testbench for the terminal escape key decoder: directed table, random sequences, scoreboard.
`timescale 1ns / 1ps

module tb;
  import tkd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ESC, ST_CSI, ST_CSI_NUM, ST_SS3
  } dec_phase_t;

  // One request as the driver hands it over; fixed marks a hand-typed expectation
  typedef struct {
    logic [7:0]       b;
    logic             nb;
    bit               fixed;
    bit               fixed_hit;
    logic [KEY_W-1:0] fixed_key;
  } key_req_t;

  localparam int NUM_REQS = 750;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       in_byte_value;
  logic             in_no_byte;
  logic             out_valid;
  logic             out_ready;
  logic [KEY_W-1:0] out_key_code;

  // Decoder mirror
  dec_phase_t dec_phase = ST_IDLE;
  logic [3:0] dec_digit = 4'd0;
  logic [KEY_W-1:0] letter_keys [8] = '{KC_UP, KC_DOWN, KC_RIGHT, KC_LEFT,
                                        KC_EMPTY, KC_END, KC_EMPTY, KC_HOME};
  logic [KEY_W-1:0] tilde_keys [9] = '{KC_EMPTY, KC_HOME, KC_EMPTY, KC_DEL,
                                       KC_END, KC_PAGE_UP, KC_PAGE_DN, KC_HOME, KC_END};

  key_req_t         sent_q [$];
  logic [KEY_W-1:0] key_q [$];
  key_req_t         dir_rows [$];
  int               err_cnt = 0;
  int               reqs_sent = 0;
  bit               calm = 1'b0;

  terminal_escape_key_decoder u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte_value(in_byte_value),
    .in_no_byte   (in_no_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_key_code (out_key_code)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Advance the mirror by one request; hit says whether a key comes out
  task automatic decode_byte(input logic [7:0] b, input logic nb,
                             output bit hit, output logic [KEY_W-1:0] key);
    dec_phase_t       nxt;
    logic [KEY_W-1:0] t;
    hit = 1'b1;
    key = KC_ESC;
    nxt = ST_IDLE;
    if (dec_phase == ST_IDLE) begin
      if (nb) hit = 1'b0;
      else if (b != BYTE_ESC) key = {1'b0, b};
      else begin
        hit = 1'b0;
        dec_phase = ST_ESC;
      end
    end else if (nb) begin
      dec_phase = ST_IDLE;
    end else begin
      case (dec_phase)
        ST_ESC: begin
          if (b == BYTE_LBRACK) nxt = ST_CSI;
          else if (b == BYTE_SS3_O) nxt = ST_SS3;
        end
        ST_CSI: begin
          if (b >= BYTE_DIG_0 && b <= BYTE_DIG_8) begin
            dec_digit = 4'(b - BYTE_DIG_0);
            nxt = ST_CSI_NUM;
          end else if (b >= BYTE_UP_A && b <= BYTE_UP_H) begin
            t = letter_keys[3'(b - BYTE_UP_A)];
            key = (t == KC_EMPTY) ? KC_ESC : t;
          end
        end
        ST_CSI_NUM: begin
          if (b == BYTE_TILDE && dec_digit <= TILDE_MAX) begin
            t = tilde_keys[dec_digit];
            key = (t == KC_EMPTY) ? KC_ESC : t;
          end
        end
        ST_SS3: begin
          if (b == BYTE_UP_H) key = KC_HOME;
          else if (b == BYTE_UP_F) key = KC_END;
        end
        default: ;
      endcase
      dec_phase = nxt;
      hit = (nxt == ST_IDLE);
    end
  endtask

  // Check results first, then predict for the request taken at this edge
  always @(posedge clk) begin
    key_req_t         r;
    bit               hit;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (key_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR: unexpected key %0d", out_key_code);
      end else begin
        want = key_q.pop_front();
        if (out_key_code !== want) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("ERROR: key_code expected %0d, got %0d", want, out_key_code);
        end
      end
    end
    if (rst_n === 1'b1 && in_valid === 1'b1 && in_ready === 1'b1 && sent_q.size() > 0) begin
      r = sent_q.pop_front();
      decode_byte(r.b, r.nb, hit, key);
      if (r.fixed) begin
        hit = r.fixed_hit;
        key = r.fixed_key;
      end
      if (hit) key_q.push_back(key);
    end
  end

  // Mostly short gaps, a few long ones, none while calm
  function automatic int gap_len(input bit allow_zero);
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55 && allow_zero) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive one request and hold it until taken
  task automatic send_req(input key_req_t r);
    int n;
    sent_q.push_back(r);
    in_valid      <= 1'b1;
    in_byte_value <= r.b;
    in_no_byte    <= r.nb;
    do @(posedge clk); while (in_ready !== 1'b1);
    reqs_sent++;
    n = gap_len(1'b1);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic add_row(input logic [7:0] b, input logic nb, input bit fixed,
                         input bit fixed_hit, input logic [KEY_W-1:0] fixed_key);
    key_req_t r;
    r.b = b;
    r.nb = nb;
    r.fixed = fixed;
    r.fixed_hit = fixed_hit;
    r.fixed_key = fixed_key;
    dir_rows.push_back(r);
  endtask

  // One random sequence: no-byte event, plain byte, complete escape sequence, or a broken one
  task automatic send_random_seq();
    logic [8:0] seq [$];
    key_req_t   r;
    int         kind;
    int         cut;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      seq.push_back({1'b1, 8'($urandom_range(0, 255))});
    end else if (kind < 25) begin
      b = 8'($urandom_range(0, 255));
      if (b == BYTE_ESC) b = ~b;
      seq.push_back({1'b0, b});
    end else begin
      seq.push_back({1'b0, BYTE_ESC});
      case ($urandom_range(0, 2))
        0: begin
          seq.push_back({1'b0, BYTE_LBRACK});
          seq.push_back({1'b0, 8'(BYTE_UP_A + $urandom_range(0, 7))});
        end
        1: begin
          seq.push_back({1'b0, BYTE_LBRACK});
          seq.push_back({1'b0, 8'(BYTE_DIG_0 + $urandom_range(0, 8))});
          seq.push_back({1'b0, BYTE_TILDE});
        end
        default: begin
          seq.push_back({1'b0, BYTE_SS3_O});
          if ($urandom_range(0, 9) == 0) seq.push_back({1'b0, 8'($urandom_range(0, 255))});
          else seq.push_back({1'b0, $urandom_range(0, 1) ? BYTE_UP_H : BYTE_UP_F});
        end
      endcase
      // broken sequence: cut short and end on noise or a missing byte
      if (kind >= 80) begin
        cut = $urandom_range(1, seq.size() - 1);
        while (seq.size() > cut) void'(seq.pop_back());
        if ($urandom_range(0, 2) == 0) seq.push_back({1'b1, 8'($urandom_range(0, 255))});
        else seq.push_back({1'b0, 8'($urandom_range(0, 255))});
      end
    end
    foreach (seq[i]) begin
      r.b = seq[i][7:0];
      r.nb = seq[i][8];
      r.fixed = 1'b0;
      r.fixed_hit = 1'b0;
      r.fixed_key = KC_EMPTY;
      send_req(r);
    end
  endtask

  // Result side back-pressure
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat (gap_len(1'b0)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Main sequence
  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_byte_value <= 8'd0;
    in_no_byte    <= 1'b0;

    // directed: extremes, each key family, empty entries, aborted sequences
    add_row(8'hFF, 1'b1, 1'b1, 1'b0, KC_EMPTY);       // missing byte while idle
    add_row(8'h00, 1'b0, 1'b1, 1'b1, 9'd0);           // NUL passes through
    add_row(8'hFF, 1'b0, 1'b1, 1'b1, 9'd255);
    add_row(BYTE_ESC, 1'b0, 1'b0, 1'b0, KC_EMPTY);
    add_row(BYTE_LBRACK, 1'b0, 1'b0, 1'b0, KC_EMPTY);
    add_row(BYTE_UP_A, 1'b0, 1'b1, 1'b1, KC_UP);
    add_row(BYTE_ESC, 1'b0, 1'b0, 1'b0, KC_EMPTY);
    add_row(BYTE_LBRACK, 1'b0, 1'b0, 1'b0, KC_EMPTY);
    add_row(8'h45, 1'b0, 1'b1, 1'b1, KC_ESC);         // ESC [ E: empty entry
    add_row(BYTE_ESC, 1'b0, 1'b0, 1'b0, KC_EMPTY);
    add_row(BYTE_SS3_O, 1'b0, 1'b0, 1'b0, KC_EMPTY);
    add_row(BYTE_UP_H, 1'b0, 1'b1, 1'b1, KC_HOME);
    add_row(BYTE_ESC, 1'b0, 1'b0, 1'b0, KC_EMPTY);
    add_row(BYTE_LBRACK, 1'b0, 1'b0, 1'b0, KC_EMPTY);
    add_row(BYTE_DIG_0, 1'b0, 1'b0, 1'b0, KC_EMPTY);
    add_row(BYTE_TILDE, 1'b0, 1'b1, 1'b1, KC_ESC);    // ESC [ 0 ~: empty entry
    add_row(BYTE_ESC, 1'b0, 1'b0, 1'b0, KC_EMPTY);
    add_row(BYTE_LBRACK, 1'b0, 1'b0, 1'b0, KC_EMPTY);
    add_row(BYTE_DIG_8, 1'b0, 1'b0, 1'b0, KC_EMPTY);
    add_row(BYTE_TILDE, 1'b0, 1'b1, 1'b1, KC_END);
    add_row(BYTE_ESC, 1'b0, 1'b0, 1'b0, KC_EMPTY);
    add_row(BYTE_ESC, 1'b0, 1'b1, 1'b1, KC_ESC);      // second ESC aborts, no reopen
    add_row(BYTE_ESC, 1'b0, 1'b0, 1'b0, KC_EMPTY);
    add_row(8'h00, 1'b1, 1'b1, 1'b1, KC_ESC);         // missing byte mid-sequence
    add_row(8'h7F, 1'b0, 1'b0, 1'b0, KC_EMPTY);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_req(dir_rows[i]);

    // random sequences with calm stretches
    while (reqs_sent < NUM_REQS) begin
      calm = ((reqs_sent / 100) % 3) == 2;
      send_random_seq();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (key_q.size() != 0 || sent_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (key_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(20_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
